// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define AHO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define AHO_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/aho_pkg.sv -----
// ---------------------------------------------------------------------------
// aho_pkg
// Types, constants and harmonic tables of the additive harmonic oscillator.
// ---------------------------------------------------------------------------
package aho_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LIMIT = 3'd3;

   localparam int CSR_DATA_W = 32;
   localparam int GAIN_W     = 12;
   localparam int DECAY_W    = 16;
   localparam int COUNT_W    = 16;
   localparam int ENV_W      = 17;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd1000;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65528;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd65535;
   localparam logic [ENV_W-1:0]   ENV_ONE     = 17'd65536;

   // Harmonic index, wide enough for the largest harmonic count.
   localparam int HARM_IDX_W = 4;
   localparam int MULT_W     = 21;
   localparam int AMP_W      = 17;

   // Step product: only bits up to 47 reach the phase.
   localparam int PROD_W = 48;

   // Sine polynomial constants.
   localparam logic [12:0] SIN_C3  = 13'd5223;
   localparam logic [15:0] SIN_C2  = 16'd42334;
   localparam logic [16:0] SIN_C1  = 17'd102944;
   localparam logic [16:0] SIN_MAX = 17'd32767;
   localparam logic [16:0] X_ONE   = 17'd65536;

   // Datapath widths of the mixer and the output scaler.
   localparam int SINE_W  = 15;
   localparam int TERM_W  = 33;
   localparam int ACC_W   = 36;
   localparam int MAG_W   = 32;
   localparam int MG_W    = 44;
   localparam int MG_LO_W = 22;
   localparam int PP_W    = 39;
   localparam int SUM_W   = 61;
   localparam int RND_W   = 14;
   localparam int RND_POS = 47;

   typedef struct packed {
      logic                  valid;
      logic [HARM_IDX_W-1:0] harmonic;
   } harm_tag_type;

   // Detuned frequency multipliers, Q5.16.
   function automatic logic [MULT_W-1:0] harm_mult(input logic [HARM_IDX_W-1:0] k);
      logic [MULT_W-1:0] m;
      case (k)
         4'd0:    m = 21'd65536;
         4'd1:    m = 21'd131213;
         4'd2:    m = 21'd196831;
         4'd3:    m = 21'd261997;
         4'd4:    m = 21'd327765;
         4'd5:    m = 21'd393445;
         4'd6:    m = 21'd426303;
         4'd7:    m = 21'd524334;
         4'd8:    m = 21'd589719;
         4'd9:    m = 21'd655596;
         4'd10:   m = 21'd720896;
         4'd11:   m = 21'd786432;
         4'd12:   m = 21'd851968;
         4'd13:   m = 21'd917504;
         4'd14:   m = 21'd983040;
         default: m = 21'd1048576;
      endcase
      return m;
   endfunction

   // Harmonic amplitudes, Q1.16; harmonics past the tenth are silent.
   function automatic logic [AMP_W-1:0] harm_amp(input logic [HARM_IDX_W-1:0] k);
      logic [AMP_W-1:0] a;
      case (k)
         4'd0:    a = 17'd65536;
         4'd1:    a = 17'd9515;
         4'd2:    a = 17'd4045;
         4'd3:    a = 17'd1997;
         4'd4:    a = 17'd1185;
         4'd5:    a = 17'd409;
         4'd6:    a = 17'd258;
         4'd7:    a = 17'd130;
         4'd8:    a = 17'd173;
         4'd9:    a = 17'd126;
         default: a = 17'd0;
      endcase
      return a;
   endfunction

endpackage

// ----- sv/aho_phase_ram.sv -----
// ---------------------------------------------------------------------------
// aho_phase_ram
// Phase accumulator store: one write and one registered read per cycle.
// Entries not yet written since reset read as zero.
// ---------------------------------------------------------------------------
module aho_phase_ram #(
   parameter int DEPTH = 10,
   parameter int WIDTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/aho_sine_eval.sv -----
// ---------------------------------------------------------------------------
// aho_sine_eval
// Six-stage pipeline: phase to quarter-wave argument, odd polynomial sine,
// clamp, and weighting by the harmonic's amplitude.
// ---------------------------------------------------------------------------
module aho_sine_eval #(
   parameter int PHASE_WIDTH      = 32,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  aho_pkg::harm_tag_type        in_tag,
   input  logic [PHASE_WIDTH-1:0]       in_phase,
   output aho_pkg::harm_tag_type        out_tag,
   output logic [aho_pkg::TERM_W-1:0]   out_term
);

   localparam int SAW    = $clog2(SINE_TABLE_DEPTH);
   localparam int STAGES = 6;

   aho_pkg::harm_tag_type tag_ff [STAGES];

   logic [SAW-1:0] addr;
   logic [15:0]    frac;
   logic [1:0]     quad1_in;
   logic [16:0]    x1_in;
   logic [33:0]    sq;
   logic [16:0]    q2_in;
   logic [29:0]    p3;
   logic [15:0]    t1_in;
   logic [32:0]    p4;
   logic [16:0]    t2_in;
   logic [33:0]    p5;
   logic [16:0]    y_full;
   logic [aho_pkg::SINE_W-1:0] y5_in;
   logic [31:0]    prod6;
   logic [aho_pkg::TERM_W-1:0] term6_in;

   logic [1:0]  quad1_ff, quad2_ff, quad3_ff, quad4_ff, quad5_ff;
   logic [16:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic [16:0] q2_ff, q3_ff;
   logic [15:0] t1_ff;
   logic [16:0] t2_ff;
   logic [aho_pkg::SINE_W-1:0] y5_ff;
   logic [aho_pkg::TERM_W-1:0] term6_ff;

   always_comb begin
      // Table address, then its position within the quadrant on 16 bits.
      addr     = in_phase[PHASE_WIDTH-1 -: SAW];
      frac     = 16'(18'(addr) << (18 - SAW));
      quad1_in = addr[SAW-1 -: 2];
      x1_in    = quad1_in[0] ? (aho_pkg::X_ONE - {1'b0, frac}) : {1'b0, frac};

      sq    = 34'(x1_ff) * 34'(x1_ff);
      q2_in = sq[32:16];

      p3    = 30'(aho_pkg::SIN_C3) * 30'(q2_ff);
      t1_in = aho_pkg::SIN_C2 - {2'b00, p3[29:16]};

      p4    = 33'(t1_ff) * 33'(q3_ff);
      t2_in = aho_pkg::SIN_C1 - p4[32:16];

      p5     = 34'(t2_ff) * 34'(x4_ff);
      y_full = p5[33:17];
      y5_in  = (y_full > aho_pkg::SIN_MAX) ? aho_pkg::SIN_MAX[aho_pkg::SINE_W-1:0]
                                           : y_full[aho_pkg::SINE_W-1:0];

      prod6    = 32'(y5_ff) * 32'(aho_pkg::harm_amp(tag_ff[4].harmonic));
      term6_in = quad5_ff[1] ? (aho_pkg::TERM_W'(0) - aho_pkg::TERM_W'(prod6))
                             : aho_pkg::TERM_W'(prod6);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      quad1_ff <= quad1_in;
      x1_ff    <= x1_in;
      quad2_ff <= quad1_ff;
      x2_ff    <= x1_ff;
      q2_ff    <= q2_in;
      quad3_ff <= quad2_ff;
      x3_ff    <= x2_ff;
      q3_ff    <= q2_ff;
      t1_ff    <= t1_in;
      quad4_ff <= quad3_ff;
      x4_ff    <= x3_ff;
      t2_ff    <= t2_in;
      quad5_ff <= quad4_ff;
      y5_ff    <= y5_in;
      term6_ff <= term6_in;
   end

   assign out_tag  = tag_ff[STAGES-1];
   assign out_term = term6_ff;

endmodule

// ----- sv/additive_harmonic_oscillator.sv -----
// ---------------------------------------------------------------------------
// additive_harmonic_oscillator
// Bank of detuned harmonic oscillators with a decaying envelope, one output
// sample per input tick.
// ---------------------------------------------------------------------------
//   channel   dir   handshake             payload
//   req       in    req_valid/req_ready   req_restart_envelope
//   rsp       out   rsp_valid/rsp_ready   rsp_sample, rsp_envelope_level
//   csr       in    csr_valid/csr_ready   csr_index, csr_data
//
// A tick runs from its transfer until the block is free for the next one:
// one phase RAM read per harmonic feeds the shared six-stage sine
// pipeline, and a six-step scaler forms the sample after the last term.
// Reset is immediate: phases read as zero until written, envelope is 1.0.
// A finished sample waits in the result register; a following sample that
// is ready before that one is taken holds until the transfer.
// ---------------------------------------------------------------------------
module additive_harmonic_oscillator #(
   parameter int NUM_HARMONICS    = 10,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_WIDTH      = 32,
   parameter int OUTPUT_WIDTH     = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart_envelope,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [OUTPUT_WIDTH-1:0]    rsp_sample,
   output logic [aho_pkg::ENV_W-1:0]         rsp_envelope_level,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aho_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aho_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
   localparam int CNT_W  = $clog2(NUM_HARMONICS + 1);
   localparam int CMP_W  = OUTPUT_WIDTH + 15;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RUN, ST_MAG, ST_GAIN, ST_ENV_LO, ST_ENV_HI, ST_ROUND, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]                   base_ff, base_in;
   logic [aho_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [aho_pkg::DECAY_W-1:0]   decay_ff, decay_in;
   logic [aho_pkg::COUNT_W-1:0]   limit_ff, limit_in;
   logic [aho_pkg::ENV_W-1:0]     env_ff, env_in;
   logic [aho_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]              issue_cnt_ff, issue_cnt_in;
   logic [CNT_W-1:0]              term_cnt_ff, term_cnt_in;
   logic [aho_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic                          neg_ff, neg_in;
   logic [aho_pkg::MAG_W-1:0]     mag_ff, mag_in;
   logic [aho_pkg::MG_W-1:0]      mg_ff, mg_in;
   logic [aho_pkg::PP_W-1:0]      plo_ff, plo_in;
   logic [aho_pkg::PP_W-1:0]      phi_ff, phi_in;
   logic [32:0]                   decay_prod_ff, decay_prod_in;
   logic [OUTPUT_WIDTH-1:0]       sample_ff, sample_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [OUTPUT_WIDTH-1:0]       rsp_sample_ff, rsp_sample_in;
   logic [aho_pkg::ENV_W-1:0]     rsp_env_ff, rsp_env_in;
   logic [aho_pkg::PROD_W-1:0]    prod_ff, prod_in;
   aho_pkg::harm_tag_type         rd_tag_ff, rd_tag_in;

   logic [52:0]                   prod_full;
   logic [aho_pkg::HARM_IDX_W-1:0] issue_harm;
   logic                          issue;
   logic [PHASE_WIDTH-1:0]        step;
   logic [PHASE_WIDTH-1:0]        rd_phase;
   aho_pkg::harm_tag_type         term_tag;
   logic [aho_pkg::TERM_W-1:0]    term;
   logic [aho_pkg::ACC_W-1:0]     acc_abs;
   logic [aho_pkg::SUM_W-1:0]     total;
   logic [CMP_W-1:0]              rnd_ext, lim, sat_mag;

   assign issue_harm = aho_pkg::HARM_IDX_W'(issue_cnt_ff);
   assign issue      = (state_ff == ST_RUN) && (issue_cnt_ff < CNT_W'(NUM_HARMONICS));
   assign prod_full  = 53'(base_ff) * 53'(aho_pkg::harm_mult(issue_harm));

   // Rescale the 32-bit phase step to the accumulator width.
   if (PHASE_WIDTH >= 32) begin : g_step_wide
      assign step = PHASE_WIDTH'(PHASE_WIDTH'(prod_ff[47:16]) << (PHASE_WIDTH - 32));
   end else begin : g_step_narrow
      assign step = prod_ff[47 -: PHASE_WIDTH];
   end

   aho_phase_ram #(
      .DEPTH (NUM_HARMONICS),
      .WIDTH (PHASE_WIDTH)
   ) u_phase_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue),
      .rd_addr (issue_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_phase),
      .wr_en   (rd_tag_ff.valid),
      .wr_addr (ADDR_W'(rd_tag_ff.harmonic)),
      .wr_data (rd_phase + step)
   );

   aho_sine_eval #(
      .PHASE_WIDTH      (PHASE_WIDTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_eval (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .in_phase (rd_phase),
      .out_tag  (term_tag),
      .out_term (term)
   );

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      gain_in       = gain_ff;
      decay_in      = decay_ff;
      limit_in      = limit_ff;
      env_in        = env_ff;
      count_in      = count_ff;
      issue_cnt_in  = issue_cnt_ff;
      term_cnt_in   = term_cnt_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      mg_in         = mg_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      decay_prod_in = decay_prod_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_env_in    = rsp_env_ff;
      prod_in       = prod_full[aho_pkg::PROD_W-1:0];
      rd_tag_in     = '{valid: issue, harmonic: issue_harm};

      acc_abs = acc_ff[aho_pkg::ACC_W-1] ? (aho_pkg::ACC_W'(0) - acc_ff) : acc_ff;
      total   = {phi_ff, {aho_pkg::MG_LO_W{1'b0}}} + aho_pkg::SUM_W'(plo_ff)
              + (aho_pkg::SUM_W'(1) << (aho_pkg::RND_POS - 1));
      rnd_ext = CMP_W'(total[aho_pkg::SUM_W-1 -: aho_pkg::RND_W]);
      // A negative sample may reach one step further than a positive one.
      lim     = neg_ff ? (CMP_W'(1) << (OUTPUT_WIDTH - 1))
                       : ((CMP_W'(1) << (OUTPUT_WIDTH - 1)) - CMP_W'(1));
      sat_mag = (rnd_ext > lim) ? lim : rnd_ext;

      if (csr_valid) begin
         unique case (csr_index)
            aho_pkg::CSR_BASE_STEP:  base_in  = csr_data;
            aho_pkg::CSR_GAIN:       gain_in  = csr_data[aho_pkg::GAIN_W-1:0];
            aho_pkg::CSR_DECAY:      decay_in = csr_data[aho_pkg::DECAY_W-1:0];
            aho_pkg::CSR_TICK_LIMIT: limit_in = csr_data[aho_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart_envelope) begin
                  env_in   = aho_pkg::ENV_ONE;
                  count_in = '0;
               end
               issue_cnt_in = '0;
               term_cnt_in  = '0;
               acc_in       = '0;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            if (term_tag.valid) begin
               acc_in = acc_ff + {{(aho_pkg::ACC_W - aho_pkg::TERM_W){term[aho_pkg::TERM_W-1]}},
                                  term};
               term_cnt_in = term_cnt_ff + CNT_W'(1);
               if (term_cnt_ff == CNT_W'(NUM_HARMONICS - 1)) begin
                  state_in = ST_MAG;
               end
            end
         end
         ST_MAG: begin
            neg_in   = acc_ff[aho_pkg::ACC_W-1];
            mag_in   = acc_abs[aho_pkg::MAG_W-1:0];
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mg_in    = aho_pkg::MG_W'(mag_ff) * aho_pkg::MG_W'(gain_ff);
            state_in = ST_ENV_LO;
         end
         ST_ENV_LO: begin
            plo_in   = aho_pkg::PP_W'(mg_ff[aho_pkg::MG_LO_W-1:0]) * aho_pkg::PP_W'(env_ff);
            state_in = ST_ENV_HI;
         end
         ST_ENV_HI: begin
            phi_in   = aho_pkg::PP_W'(mg_ff[aho_pkg::MG_W-1:aho_pkg::MG_LO_W])
                     * aho_pkg::PP_W'(env_ff);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            sample_in     = neg_ff ? OUTPUT_WIDTH'(CMP_W'(0) - sat_mag)
                                   : OUTPUT_WIDTH'(sat_mag);
            decay_prod_in = 33'(env_ff) * 33'(decay_ff);
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_env_in    = env_ff;
               if (count_ff < limit_ff) begin
                  count_in = count_ff + aho_pkg::COUNT_W'(1);
                  env_in   = decay_prod_ff[32:16];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         gain_ff      <= aho_pkg::GAIN_RESET;
         decay_ff     <= aho_pkg::DECAY_RESET;
         limit_ff     <= aho_pkg::LIMIT_RESET;
         env_ff       <= aho_pkg::ENV_ONE;
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         term_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         gain_ff      <= gain_in;
         decay_ff     <= decay_in;
         limit_ff     <= limit_in;
         env_ff       <= env_in;
         count_ff     <= count_in;
         issue_cnt_ff <= issue_cnt_in;
         term_cnt_ff  <= term_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_tag_ff    <= rd_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      mg_ff         <= mg_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      decay_prod_ff <= decay_prod_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_env_ff    <= rsp_env_in;
      prod_ff       <= prod_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_envelope_level = rsp_env_ff;

endmodule

// ----- sv/aho_checker.sv -----
// ---------------------------------------------------------------------------
// aho_checker
// Port-level checks of the oscillator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aho_checker #(
   parameter int OUTPUT_WIDTH = 12
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [OUTPUT_WIDTH-1:0] rsp_sample,
   input logic [aho_pkg::ENV_W-1:0]      rsp_envelope_level
);

   logic                                      rsp_stall;
   logic                                      req_take;
   logic                                      env_over;
   logic [OUTPUT_WIDTH+aho_pkg::ENV_W-1:0]    rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign env_over    = rsp_envelope_level > aho_pkg::ENV_ONE;
   assign rsp_payload = {rsp_sample, rsp_envelope_level};

   // No result is pending right after reset.
   `AHO_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result stays valid and keeps its payload.
   `AHO_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "stalled result dropped")
   `AHO_ASSERT(a_data_hold, clock, reset, rsp_stall |=> $stable(rsp_payload), "result changed")

   // The envelope never rises above full level.
   `AHO_ASSERT(a_env_range, clock, reset, rsp_valid |-> !env_over, "envelope above 1.0")

   // A tick occupies the block after its transfer.
   `AHO_ASSERT(a_one_tick, clock, reset, req_take |=> !req_ready, "tick taken while busy")

endmodule

bind additive_harmonic_oscillator aho_checker #(.OUTPUT_WIDTH(OUTPUT_WIDTH)) u_aho_checker (.*);

// ----- bench/tb_additive_harmonic_oscillator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_additive_harmonic_oscillator
// Self-checking bench for the oscillator bank. A burst driver sends sample
// ticks from a queue, and a monitor predicts each tick's sample and envelope
// level at its transfer and checks them against the results in order.
// Register settings change between phases, once the block has drained.
// ---------------------------------------------------------------------------
module tb_additive_harmonic_oscillator;

   localparam int NUM_HARM    = 10;
   localparam int SINE_DEPTH  = 1024;
   localparam int OUT_W       = 12;
   localparam int TICK_CYCLES = NUM_HARM + 14;
   localparam int RANDOM_TICKS = 1300;

   localparam longint SAMPLE_MAX = 2047;
   localparam longint SAMPLE_MIN = -2048;

   localparam logic [aho_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd4;

   localparam int unsigned DETUNE_Q16 [NUM_HARM] = '{
      65536, 131213, 196831, 261997, 327765, 393445, 426303, 524334, 589719, 655596
   };
   localparam int unsigned AMP_Q16 [NUM_HARM] = '{
      65536, 9515, 4045, 1997, 1185, 409, 258, 130, 173, 126
   };

   typedef struct {
      logic signed [OUT_W-1:0]    sample;
      logic [aho_pkg::ENV_W-1:0]  level;
   } osc_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_restart_envelope = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_sample;
   logic [aho_pkg::ENV_W-1:0]      rsp_envelope_level;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [aho_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [aho_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Predicted oscillator state and register copies.
   logic [31:0]                 osc_phase [NUM_HARM];
   logic [aho_pkg::ENV_W-1:0]   osc_env;
   logic [aho_pkg::COUNT_W-1:0] osc_count;
   logic [31:0]                 cfg_base;
   logic [aho_pkg::GAIN_W-1:0]  cfg_gain;
   logic [aho_pkg::DECAY_W-1:0] cfg_decay;
   logic [aho_pkg::COUNT_W-1:0] cfg_limit;

   logic           tick_queue [$];
   osc_result_type expected_samples [$];
   bit             tick_taken = 1'b0;
   int             mismatch_count = 0;
   int             gap_left = 0;
   int             burst_left = 0;
   int             stall_left = 0;

   additive_harmonic_oscillator DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_restart_envelope (req_restart_envelope),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sample           (rsp_sample),
      .rsp_envelope_level   (rsp_envelope_level),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   function automatic void reset_model();
      for (int k = 0; k < NUM_HARM; k++) begin
         osc_phase[k] = '0;
      end
      osc_env   = aho_pkg::ENV_ONE;
      osc_count = '0;
      cfg_base  = '0;
      cfg_gain  = aho_pkg::GAIN_RESET;
      cfg_decay = aho_pkg::DECAY_RESET;
      cfg_limit = aho_pkg::LIMIT_RESET;
   endfunction

   function automatic void apply_csr(input logic [aho_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [aho_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         aho_pkg::CSR_BASE_STEP:  cfg_base  = data;
         aho_pkg::CSR_GAIN:       cfg_gain  = data[aho_pkg::GAIN_W-1:0];
         aho_pkg::CSR_DECAY:      cfg_decay = data[aho_pkg::DECAY_W-1:0];
         aho_pkg::CSR_TICK_LIMIT: cfg_limit = data[aho_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // Quarter-wave polynomial sine, Q1.15, addressed by the top phase bits.
   function automatic logic signed [16:0] sine_of(input logic [31:0] phase);
      logic [63:0] idx, f, r, x, q, t, y;
      logic [1:0]  quad;
      idx  = (64'(phase) * 64'(SINE_DEPTH)) >> 32;
      f    = (idx << 18) / 64'(SINE_DEPTH);
      quad = f[17:16];
      r    = {48'd0, f[15:0]};
      x    = quad[0] ? (64'd65536 - r) : r;
      q    = (x * x) >> 16;
      t    = (64'd5223 * q) >> 16;
      t    = 64'd42334 - t;
      t    = (t * q) >> 16;
      t    = 64'd102944 - t;
      y    = (t * x) >> 17;
      if (y > 64'd32767) begin
         y = 64'd32767;
      end
      return quad[1] ? -$signed(17'(y)) : $signed(17'(y));
   endfunction

   function automatic void predict_tick(input logic restart);
      longint         acc;
      longint         val;
      logic [63:0]    mag;
      logic [63:0]    step;
      osc_result_type res;
      if (restart) begin
         osc_env   = aho_pkg::ENV_ONE;
         osc_count = '0;
      end
      acc = 0;
      for (int k = 0; k < NUM_HARM; k++) begin
         acc += longint'(sine_of(osc_phase[k])) * longint'(AMP_Q16[k]);
      end
      mag = (acc < 0) ? 64'(-acc) : 64'(acc);
      mag = mag * 64'(cfg_gain) * 64'(osc_env);
      mag = (mag + (64'd1 << 46)) >> 47;
      val = (acc < 0) ? -longint'(mag) : longint'(mag);
      if (val > SAMPLE_MAX) val = SAMPLE_MAX;
      if (val < SAMPLE_MIN) val = SAMPLE_MIN;
      res.sample = val[OUT_W-1:0];
      res.level  = osc_env;
      expected_samples.push_back(res);
      // Phases advance only after the sample has been formed.
      for (int k = 0; k < NUM_HARM; k++) begin
         step = (64'(cfg_base) * 64'(DETUNE_Q16[k])) >> 16;
         osc_phase[k] = osc_phase[k] + step[31:0];
      end
      if (osc_count < cfg_limit) begin
         osc_count = osc_count + aho_pkg::COUNT_W'(1);
         mag       = (64'(osc_env) * 64'(cfg_decay)) >> 16;
         osc_env   = mag[aho_pkg::ENV_W-1:0];
      end
   endfunction

   // Sender: bursts of ticks separated by random gaps.
   always @(negedge clock) begin : tick_driver
      logic nv, nr;
      nv = req_valid;
      nr = req_restart_envelope;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (tick_taken) begin
            tick_taken = 1'b0;
            nv = 1'b0;
         end
         if (!nv) begin
            nr = 1'($urandom_range(0, 1));
            if (gap_left > 0) begin
               gap_left--;
            end else if (tick_queue.size() > 0) begin
               nr = tick_queue.pop_front();
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
      end
      req_valid <= nv;
      req_restart_envelope <= nr;
   end

   // Receiver: mostly short stalls, now and then a long one, and long ready stretches.
   always @(negedge clock) begin : rsp_stall
      logic nr;
      nr = rsp_ready;
      if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_ready) begin
         nr = 1'b0;
         stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else begin
         nr = 1'b1;
         stall_left = $urandom_range(0, 60);
      end
      rsp_ready <= nr;
   end

   always @(posedge clock) begin : osc_monitor
      osc_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("sample with no tick pending", longint'(rsp_sample), 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample) begin
                  report_mismatch("sample", longint'(rsp_sample), longint'(want.sample));
               end
               if (rsp_envelope_level !== want.level) begin
                  report_mismatch("envelope_level", longint'(rsp_envelope_level),
                                  longint'(want.level));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_tick(req_restart_envelope);
            tick_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
         end
      end
   end

   task automatic write_reg(input logic [aho_pkg::CSR_IDX_W-1:0] idx,
                            input logic [aho_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= aho_pkg::CSR_IDX_W'($urandom);
      csr_data  <= $urandom;
   endtask

   // Waits until every tick has been sent and answered, then lets the pipeline settle.
   task automatic wait_idle();
      @(posedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * TICK_CYCLES) @(posedge clock);
   endtask

   task automatic run_pattern(input logic [15:0] pat, input int count);
      for (int i = 0; i < count; i++) begin
         tick_queue.push_back(pat[i]);
      end
      wait_idle();
   endtask

   task automatic run_ticks(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) begin
         tick_queue.push_back($urandom_range(0, 99) < restart_pct);
      end
      wait_idle();
   endtask

   initial begin : stimulus
      int sent;
      int n;
      logic [31:0] data;
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero step keeps every phase at zero.
      run_pattern(16'b010, 3);

      // Quarter-cycle step at full gain drives the sum into both rails.
      write_reg(aho_pkg::CSR_BASE_STEP, 32'h4000_0000);
      write_reg(aho_pkg::CSR_GAIN, 32'hFFFF_FFFF);
      write_reg(aho_pkg::CSR_DECAY, 32'h0000_FFFF);
      write_reg(aho_pkg::CSR_TICK_LIMIT, 32'h0000_FFFF);
      run_pattern(16'b010001, 6);

      // Zero decay with a short hold, then a hold of zero freezes at full level.
      write_reg(aho_pkg::CSR_DECAY, 32'd0);
      write_reg(aho_pkg::CSR_TICK_LIMIT, 32'd3);
      run_pattern(16'b0001, 4);
      write_reg(aho_pkg::CSR_TICK_LIMIT, 32'd0);
      run_pattern(16'b01, 2);

      // Largest step with zero gain, then the smallest nonzero gain.
      write_reg(aho_pkg::CSR_BASE_STEP, 32'hFFFF_FFFF);
      write_reg(aho_pkg::CSR_GAIN, 32'd0);
      run_pattern(16'b10, 2);
      write_reg(aho_pkg::CSR_GAIN, 32'd1);
      run_pattern(16'b0, 1);

      // A hold limit written below the running count freezes the envelope at once.
      write_reg(aho_pkg::CSR_GAIN, 32'd4095);
      write_reg(aho_pkg::CSR_DECAY, 32'd65000);
      write_reg(aho_pkg::CSR_TICK_LIMIT, 32'd65535);
      run_pattern(16'b00001, 5);
      write_reg(aho_pkg::CSR_TICK_LIMIT, 32'd2);
      run_pattern(16'b00, 2);

      // Writes to unmapped indexes must leave every setting alone.
      write_reg(CSR_FIRST_UNUSED + aho_pkg::CSR_IDX_W'($urandom_range(0, 3)), $urandom);
      run_pattern(16'b0, 1);

      sent = 0;
      while (sent < RANDOM_TICKS) begin
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       data = 32'd0;
               1:       data = 32'hFFFF_FFFF;
               2:       data = $urandom_range(1, 32'h0100_0000);
               default: data = $urandom;
            endcase
            write_reg(aho_pkg::CSR_BASE_STEP, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            data = $urandom;
            case ($urandom_range(0, 3))
               0:       data[aho_pkg::GAIN_W-1:0] = '0;
               1:       data[aho_pkg::GAIN_W-1:0] = '1;
               default: ;
            endcase
            write_reg(aho_pkg::CSR_GAIN, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            data = $urandom;
            case ($urandom_range(0, 5))
               0:       data[aho_pkg::DECAY_W-1:0] = '0;
               1:       data[aho_pkg::DECAY_W-1:0] = '1;
               2:       ;
               default: data[aho_pkg::DECAY_W-1:0] =
                           aho_pkg::DECAY_W'($urandom_range(60000, 65535));
            endcase
            write_reg(aho_pkg::CSR_DECAY, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            data = $urandom;
            case ($urandom_range(0, 4))
               0:       data[aho_pkg::COUNT_W-1:0] = '0;
               1:       data[aho_pkg::COUNT_W-1:0] = '1;
               default: data[aho_pkg::COUNT_W-1:0] = aho_pkg::COUNT_W'($urandom_range(0, 200));
            endcase
            write_reg(aho_pkg::CSR_TICK_LIMIT, data);
         end
         if ($urandom_range(0, 5) == 0) begin
            write_reg(CSR_FIRST_UNUSED + aho_pkg::CSR_IDX_W'($urandom_range(0, 3)), $urandom);
         end
         n = $urandom_range(20, 80);
         run_ticks(n, $urandom_range(0, 25));
         sent += n;
      end

      wait_idle();
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
